@@ hw/rtl/olist_pkg.sv @@
package olist_pkg;

  localparam int unsigned OLIST_CAPACITY = 16;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned ValW      = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountOutW = 5;

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 40;

  localparam logic [CmdW-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CmdW-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CmdW-1:0] CMD_DELETE    = 3'd2;
  localparam logic [CmdW-1:0] CMD_DUMP      = 3'd3;
  localparam logic [CmdW-1:0] CMD_CLEAR     = 3'd4;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [StatusW-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic               load;
    logic               ptr_clr;
    logic               ptr_last;
    logic               ptr_inc;
    logic               ptr_dec;
    logic               rd;
    logic               wr_up;
    logic               wr_down;
    logic               wr_front;
    logic               wr_back;
    logic               cnt_inc;
    logic               cnt_dec;
    logic               cnt_clr;
    logic               res_load;
    logic               res_from_mem;
    logic               res_last;
    logic [StatusW-1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ptr_zero;
    logic ptr_last;
    logic found;
    logic slot_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/olist_ctrl.sv @@
module olist_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_valid_i,
  input  logic [olist_pkg::CmdW-1:0] cmd_i,
  output logic                      s_ready_o,
  input  olist_pkg::dp_stat_t       stat_i,
  output olist_pkg::dp_cmd_t        cmd_o
);
  import olist_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RESP     = 4'd1;
  localparam logic [3:0] S_FS_FIRST = 4'd2;
  localparam logic [3:0] S_FS_RUN   = 4'd3;
  localparam logic [3:0] S_FS_FLUSH = 4'd4;
  localparam logic [3:0] S_FRONT_WR = 4'd5;
  localparam logic [3:0] S_BACK_WR  = 4'd6;
  localparam logic [3:0] S_DEL_FIRST = 4'd7;
  localparam logic [3:0] S_DEL_RUN  = 4'd8;
  localparam logic [3:0] S_DEL_FLUSH = 4'd9;
  localparam logic [3:0] S_DEL_END  = 4'd10;
  localparam logic [3:0] S_DUMP_RD  = 4'd11;
  localparam logic [3:0] S_DUMP_OUT = 4'd12;

  logic [3:0]         state_q, state_d;
  logic [StatusW-1:0] status_q, status_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    status_d = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (cmd_i)
            CMD_INS_FRONT: begin
              if (stat_i.full) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else if (stat_i.empty) begin
                state_d = S_FRONT_WR;
              end else begin
                cmd_o.ptr_last = 1'b1;
                state_d        = S_FS_FIRST;
              end
            end
            CMD_INS_BACK: begin
              if (stat_i.full) begin
                status_d = ST_FULL;
                state_d  = S_RESP;
              end else begin
                state_d = S_BACK_WR;
              end
            end
            CMD_DELETE: begin
              if (stat_i.empty) begin
                status_d = ST_NOT_FOUND;
                state_d  = S_RESP;
              end else begin
                cmd_o.ptr_clr = 1'b1;
                state_d       = S_DEL_FIRST;
              end
            end
            CMD_DUMP: begin
              if (stat_i.empty) begin
                status_d = ST_EMPTY;
                state_d  = S_RESP;
              end else begin
                cmd_o.ptr_clr = 1'b1;
                state_d       = S_DUMP_RD;
              end
            end
            CMD_CLEAR: begin
              cmd_o.cnt_clr = 1'b1;
              status_d      = ST_OK;
              state_d       = S_RESP;
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        if (stat_i.slot_free) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = status_q;
          cmd_o.res_last   = 1'b1;
          state_d          = S_IDLE;
        end
      end
      // front insert: move entries up by one, back to front
      S_FS_FIRST: begin
        cmd_o.rd = 1'b1;
        if (stat_i.ptr_zero) begin
          state_d = S_FS_FLUSH;
        end else begin
          cmd_o.ptr_dec = 1'b1;
          state_d       = S_FS_RUN;
        end
      end
      S_FS_RUN: begin
        cmd_o.rd    = 1'b1;
        cmd_o.wr_up = 1'b1;
        if (stat_i.ptr_zero) begin
          state_d = S_FS_FLUSH;
        end else begin
          cmd_o.ptr_dec = 1'b1;
        end
      end
      S_FS_FLUSH: begin
        cmd_o.wr_up = 1'b1;
        state_d     = S_FRONT_WR;
      end
      S_FRONT_WR: begin
        cmd_o.wr_front = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        status_d       = ST_OK;
        state_d        = S_RESP;
      end
      S_BACK_WR: begin
        cmd_o.wr_back = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        status_d      = ST_OK;
        state_d       = S_RESP;
      end
      // delete: scan front to back, move everything after the match down
      S_DEL_FIRST: begin
        cmd_o.rd = 1'b1;
        if (stat_i.ptr_last) begin
          state_d = S_DEL_FLUSH;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = S_DEL_RUN;
        end
      end
      S_DEL_RUN: begin
        cmd_o.rd      = 1'b1;
        cmd_o.wr_down = 1'b1;
        if (stat_i.ptr_last) begin
          state_d = S_DEL_FLUSH;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_DEL_FLUSH: begin
        cmd_o.wr_down = 1'b1;
        state_d       = S_DEL_END;
      end
      S_DEL_END: begin
        if (stat_i.found) begin
          cmd_o.cnt_dec = 1'b1;
          status_d      = ST_OK;
        end else begin
          status_d = ST_NOT_FOUND;
        end
        state_d = S_RESP;
      end
      S_DUMP_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (stat_i.slot_free) begin
          cmd_o.res_load     = 1'b1;
          cmd_o.res_from_mem = 1'b1;
          cmd_o.res_status   = ST_OK;
          cmd_o.res_last     = stat_i.ptr_last;
          if (stat_i.ptr_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.ptr_inc = 1'b1;
            state_d       = S_DUMP_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

@@ hw/rtl/olist_dp.sv @@
module olist_dp #(
  parameter int unsigned CAPACITY = olist_pkg::OLIST_CAPACITY
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [olist_pkg::ValW-1:0]  item_value_i,
  input  olist_pkg::dp_cmd_t                 cmd_i,
  output olist_pkg::dp_stat_t                stat_o,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic [olist_pkg::StatusW-1:0]      status_o,
  output logic signed [olist_pkg::ValW-1:0]  out_value_o,
  output logic                               last_o,
  output logic [olist_pkg::CountOutW-1:0]    entry_count_o
);
  import olist_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [ValW-1:0] mem [CAPACITY];

  logic [CW-1:0]          cnt_q, cnt_d;
  logic [AW-1:0]          ptr_q, ptr_d;
  logic [AW-1:0]          raddr_q;
  logic signed [ValW-1:0] rdata_q;
  logic signed [ValW-1:0] val_q;
  logic                   found_q, found_d;

  logic                   we;
  logic [AW-1:0]          waddr;
  logic signed [ValW-1:0] wdata;

  logic                   out_valid_q, out_valid_d;
  logic [StatusW-1:0]     out_status_q;
  logic signed [ValW-1:0] out_value_q;
  logic                   out_last_q;
  logic [CountOutW-1:0]   out_count_q;

  assign stat_o.full      = (cnt_q == CW'(CAPACITY));
  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.ptr_zero  = (ptr_q == '0);
  assign stat_o.ptr_last  = ((CW'(ptr_q) + CW'(1)) == cnt_q);
  assign stat_o.found     = found_q;
  assign stat_o.slot_free = !out_valid_q || m_ready_i;

  always_comb begin
    priority if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_last) begin
      ptr_d = AW'(cnt_q - CW'(1));
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + AW'(1);
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - AW'(1);
    end else begin
      ptr_d = ptr_q;
    end
  end

  always_comb begin
    priority if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_comb begin
    found_d = found_q;
    if (cmd_i.load) begin
      found_d = 1'b0;
    end else if (cmd_i.wr_down && !found_q && (rdata_q == val_q)) begin
      found_d = 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = val_q;
    priority if (cmd_i.wr_up) begin
      we    = 1'b1;
      waddr = raddr_q + AW'(1);
      wdata = rdata_q;
    end else if (cmd_i.wr_down) begin
      we    = found_q;
      waddr = raddr_q - AW'(1);
      wdata = rdata_q;
    end else if (cmd_i.wr_front) begin
      we    = 1'b1;
      waddr = '0;
    end else if (cmd_i.wr_back) begin
      we    = 1'b1;
      waddr = AW'(cnt_q);
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem[ptr_q];
      raddr_q <= ptr_q;
    end
    if (cmd_i.load) begin
      val_q <= item_value_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.res_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_status_q <= cmd_i.res_status;
      out_value_q  <= cmd_i.res_from_mem ? rdata_q : '0;
      out_last_q   <= cmd_i.res_last;
      out_count_q  <= CountOutW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o     = out_valid_q;
  assign status_o      = out_status_q;
  assign out_value_o   = out_value_q;
  assign last_o        = out_last_q;
  assign entry_count_o = out_count_q;

endmodule

@@ hw/rtl/ordered_list_engine_core.sv @@
// Ordered list of up to CAPACITY signed 32-bit values, index 0 at the front.
// Command channel s_axis: one beat per command (insert front, insert back,
// delete first match, dump, clear); unknown command codes are taken and
// dropped without a result. Result channel m_axis: one beat per command,
// or one beat per entry for a dump of a non-empty list, tlast on the final
// beat of a command. entry_count is the list length after the command.
// One command is in flight at a time; s_axis_tready is high only while the
// sequencer is idle, so the next command is taken at the earliest on the
// edge at which the last result beat of the previous one can be taken.
// Steps from accept to result beat:
//   insert back: one write; clear, refused insert, empty delete or dump: none
//   insert front: moves every entry up, then writes the front entry
//     (through the one read port and one write port of the entry memory)
//   delete: one scan that also moves the tail down
//   dump: a registered read before each entry's beat
// Reset empties the list at once; no memory clearing is needed.
// A stalled m_axis holds its beat in the output register; a new command is
// still taken and its result waits until the output register frees up.
module ordered_list_engine_core #(
  parameter int unsigned CAPACITY = olist_pkg::OLIST_CAPACITY
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [2:0] command, [34:3] item_value, [39:35] zero
  input  logic [olist_pkg::InTdataW-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [33:2] out_value, [38:34] entry_count, [39] zero
  output logic [olist_pkg::OutTdataW-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast
);
  import olist_pkg::*;

  dp_cmd_t                dp_cmd;
  dp_stat_t               dp_stat;
  logic [CmdW-1:0]        command;
  logic signed [ValW-1:0] item_value;
  logic [StatusW-1:0]     status;
  logic signed [ValW-1:0] out_value;
  logic [CountOutW-1:0]   entry_count;

  assign command    = s_axis_tdata[0 +: CmdW];
  assign item_value = s_axis_tdata[CmdW +: ValW];

  olist_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .cmd_i     (command),
    .s_ready_o (s_axis_tready),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd)
  );

  olist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_value_i  (item_value),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .status_o      (status),
    .out_value_o   (out_value),
    .last_o        (m_axis_tlast),
    .entry_count_o (entry_count)
  );

  assign m_axis_tdata = {
    {(OutTdataW - StatusW - ValW - CountOutW){1'b0}},
    entry_count,
    out_value,
    status
  };

endmodule
